>>> rtl/rgbseq_pkg.sv
package rgbseq_pkg;

  localparam logic [6:0] LEVEL_MAX    = 7'd100;
  localparam logic [6:0] LEVEL_UNSEEN = 7'd101;

  localparam logic [7:0] MASK_UNSEEN = 8'hFF;
  localparam logic [7:0] MASK_START  = 8'h3F;

  localparam logic [7:0] KEEP_RED   = 8'h33;
  localparam logic [7:0] KEEP_GREEN = 8'h0F;
  localparam logic [7:0] KEEP_BLUE  = 8'h3C;
  localparam logic [7:0] ON_RED     = 8'h0C;
  localparam logic [7:0] ON_GREEN   = 8'h30;
  localparam logic [7:0] ON_BLUE    = 8'h03;

  localparam logic [7:0] FULL_CODE_RESET = 8'd255;

  localparam logic [1:0] ADDR_BLUE   = 2'd0;
  localparam logic [1:0] ADDR_RED    = 2'd1;
  localparam logic [1:0] ADDR_GREEN  = 2'd2;
  localparam logic [1:0] ADDR_ENABLE = 2'd3;

  // Positions of the pending writes, in the order they are sent.
  localparam int WR_RED    = 0;
  localparam int WR_GREEN  = 1;
  localparam int WR_BLUE   = 2;
  localparam int WR_ENABLE = 3;

  // Division by 99 of a product below 2**15 as a multiply by
  // ceil(2**21 / 99) and a shift right by 21; exact over that range.
  localparam logic [14:0] RECIP_99    = 15'd21184;
  localparam int          RECIP_SHIFT = 21;

  typedef struct packed {
    logic [3:0]  wr;
    logic [14:0] prod_red;
    logic [14:0] prod_green;
    logic [14:0] prod_blue;
    logic [7:0]  mask;
  } rgbseq_work_t;

  typedef struct packed {
    logic         valid;
    rgbseq_work_t work;
  } rgbseq_job_t;

  function automatic logic [6:0] clamp_level(logic [7:0] v);
    return (v > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : v[6:0];
  endfunction

  function automatic logic [7:0] div_99(logic [14:0] p);
    logic [29:0] t;
    t = p * RECIP_99;
    return t[RECIP_SHIFT+7:RECIP_SHIFT];
  endfunction

endpackage

>>> rtl/rgbseq_if.sv
interface rgbseq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

interface rgbseq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_address;
  logic [7:0] reg_value;
  logic       last_write;

  modport source (output valid, output reg_address, output reg_value, output last_write,
                  input ready);
  modport sink (input valid, input reg_address, input reg_value, input last_write,
                output ready);
endinterface

>>> rtl/rgbseq_decide.sv
module rgbseq_decide (
  input  logic                     clk,
  input  logic                     rst_n,
  rgbseq_in_if.sink                in_req,
  input  logic                     cfg_wr_en,
  input  logic [7:0]               cfg_wr_data,
  input  logic                     burst_free,
  output rgbseq_pkg::rgbseq_job_t  job
);

  logic       p_valid_r;
  logic [6:0] p_red_r;
  logic [6:0] p_green_r;
  logic [6:0] p_blue_r;

  logic       job_valid_r;
  rgbseq_pkg::rgbseq_work_t work_r;
  rgbseq_pkg::rgbseq_work_t work_nxt;

  logic [6:0] prev_red_r;
  logic [6:0] prev_green_r;
  logic [6:0] prev_blue_r;
  logic [7:0] prev_mask_r;
  logic [7:0] full_code_r;

  logic       in_fire;
  logic       q_move;
  logic       p_move;
  logic       chg_red;
  logic       chg_green;
  logic       chg_blue;
  logic [7:0] mask;
  logic [6:0] red_m1;
  logic [6:0] green_m1;
  logic [6:0] blue_m1;

  assign q_move       = job_valid_r && burst_free;
  assign p_move       = p_valid_r && (!job_valid_r || q_move);
  assign in_req.ready = rst_n && (!p_valid_r || p_move);
  assign in_fire      = in_req.valid && in_req.ready;

  assign job.valid = job_valid_r;
  assign job.work  = work_r;

  always_comb begin
    chg_red   = p_red_r != prev_red_r;
    chg_green = p_green_r != prev_green_r;
    chg_blue  = p_blue_r != prev_blue_r;

    mask = (prev_mask_r == rgbseq_pkg::MASK_UNSEEN) ? rgbseq_pkg::MASK_START : prev_mask_r;
    if (chg_red) begin
      mask = (p_red_r == 7'd0) ? (mask & rgbseq_pkg::KEEP_RED) : (mask | rgbseq_pkg::ON_RED);
    end
    if (chg_green) begin
      mask = (p_green_r == 7'd0) ? (mask & rgbseq_pkg::KEEP_GREEN)
                                 : (mask | rgbseq_pkg::ON_GREEN);
    end
    if (chg_blue) begin
      mask = (p_blue_r == 7'd0) ? (mask & rgbseq_pkg::KEEP_BLUE)
                                : (mask | rgbseq_pkg::ON_BLUE);
    end

    red_m1   = p_red_r - 7'd1;
    green_m1 = p_green_r - 7'd1;
    blue_m1  = p_blue_r - 7'd1;

    work_nxt.wr[rgbseq_pkg::WR_RED]    = chg_red && (p_red_r != 7'd0);
    work_nxt.wr[rgbseq_pkg::WR_GREEN]  = chg_green && (p_green_r != 7'd0);
    work_nxt.wr[rgbseq_pkg::WR_BLUE]   = chg_blue && (p_blue_r != 7'd0);
    work_nxt.wr[rgbseq_pkg::WR_ENABLE] = mask != prev_mask_r;
    work_nxt.prod_red   = 15'(red_m1) * 15'(full_code_r);
    work_nxt.prod_green = 15'(green_m1) * 15'(full_code_r);
    work_nxt.prod_blue  = 15'(blue_m1) * 15'(full_code_r);
    work_nxt.mask       = mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r    <= 1'b0;
      job_valid_r  <= 1'b0;
      prev_red_r   <= rgbseq_pkg::LEVEL_UNSEEN;
      prev_green_r <= rgbseq_pkg::LEVEL_UNSEEN;
      prev_blue_r  <= rgbseq_pkg::LEVEL_UNSEEN;
      prev_mask_r  <= rgbseq_pkg::MASK_UNSEEN;
      full_code_r  <= rgbseq_pkg::FULL_CODE_RESET;
    end else begin
      p_valid_r   <= in_fire || (p_valid_r && !p_move);
      job_valid_r <= p_move || (job_valid_r && !q_move);
      if (cfg_wr_en) begin
        full_code_r <= cfg_wr_data;
      end
      if (p_move) begin
        prev_red_r   <= p_red_r;
        prev_green_r <= p_green_r;
        prev_blue_r  <= p_blue_r;
        prev_mask_r  <= mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_red_r   <= rgbseq_pkg::clamp_level(in_req.red_level);
      p_green_r <= rgbseq_pkg::clamp_level(in_req.green_level);
      p_blue_r  <= rgbseq_pkg::clamp_level(in_req.blue_level);
    end
    if (p_move) begin
      work_r <= work_nxt;
    end
  end

endmodule

>>> rtl/rgbseq_burst.sv
module rgbseq_burst (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rgbseq_pkg::rgbseq_job_t  job,
  output logic                     burst_free,
  rgbseq_out_if.source             out_req
);

  logic [3:0] pend_r;
  logic [7:0] cur_red_r;
  logic [7:0] cur_green_r;
  logic [7:0] cur_blue_r;
  logic [7:0] mask_r;

  logic [3:0] sel;
  logic       out_fire;
  logic       load;

  always_comb begin
    sel                 = 4'b0000;
    out_req.reg_address = rgbseq_pkg::ADDR_ENABLE;
    out_req.reg_value   = mask_r;
    if (pend_r[rgbseq_pkg::WR_RED]) begin
      sel[rgbseq_pkg::WR_RED] = 1'b1;
      out_req.reg_address     = rgbseq_pkg::ADDR_RED;
      out_req.reg_value       = cur_red_r;
    end else if (pend_r[rgbseq_pkg::WR_GREEN]) begin
      sel[rgbseq_pkg::WR_GREEN] = 1'b1;
      out_req.reg_address       = rgbseq_pkg::ADDR_GREEN;
      out_req.reg_value         = cur_green_r;
    end else if (pend_r[rgbseq_pkg::WR_BLUE]) begin
      sel[rgbseq_pkg::WR_BLUE] = 1'b1;
      out_req.reg_address      = rgbseq_pkg::ADDR_BLUE;
      out_req.reg_value        = cur_blue_r;
    end else begin
      sel[rgbseq_pkg::WR_ENABLE] = pend_r[rgbseq_pkg::WR_ENABLE];
    end
  end

  assign out_req.valid      = |pend_r;
  assign out_req.last_write = (pend_r & (pend_r - 4'd1)) == 4'd0;
  assign out_fire           = out_req.valid && out_req.ready;
  assign burst_free         = !out_req.valid || (out_fire && out_req.last_write);
  assign load               = job.valid && burst_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'b0000;
    end else if (load) begin
      pend_r <= job.work.wr;
    end else if (out_fire) begin
      pend_r <= pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_red_r   <= rgbseq_pkg::div_99(job.work.prod_red);
      cur_green_r <= rgbseq_pkg::div_99(job.work.prod_green);
      cur_blue_r  <= rgbseq_pkg::div_99(job.work.prod_blue);
      mask_r      <= job.work.mask;
    end
  end

endmodule

>>> rtl/rgb_led_register_write_sequencer.sv
// A request passes the input register, then the decision and product register, then the write
// buffer, from which its first register write is offered; a busy write buffer can hold it back.
// Throughput: one request per cycle while requests cause at most one write each and the output
// is ready; a request causing n writes holds the write buffer until all n are taken (up to four).
// Reset: the pipeline empties, the stored levels read as unseen, the enable mask as never
// written, and the full power current code returns to 255.
module rgb_led_register_write_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  rgbseq_in_if.sink     in_req,
  rgbseq_out_if.source  out_req,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data
);

  rgbseq_pkg::rgbseq_job_t job;
  logic                    burst_free;

  rgbseq_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .burst_free  (burst_free),
    .job         (job)
  );

  rgbseq_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .burst_free (burst_free),
    .out_req    (out_req)
  );

  a_enable_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && (out_req.reg_address == rgbseq_pkg::ADDR_ENABLE) |-> out_req.last_write)
    else $error("enable register write is not the last write of its request");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    job.valid && !burst_free |=> job.valid && $stable(job))
    else $error("decided request changed while the write buffer was busy");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_req.valid && out_req.ready && !out_req.last_write |=> out_req.valid)
    else $error("write burst ended before its last write");

endmodule

>>> dv/tb.sv
module tb;

  localparam int SCALE_DIV     = 99;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_COUNT   = 7;
  localparam int PHASE_REQS    = 27;
  localparam int RED           = 0;
  localparam int GREEN         = 1;
  localparam int BLUE          = 2;

  typedef struct packed {
    logic [1:0] address;
    logic [7:0] value;
    logic       last_write;
  } reg_write_t;

  class led_write_board;
    reg_write_t pending_writes[$];
    logic [7:0] full_code;
    logic [6:0] prev_level[3];
    logic [7:0] prev_mask;
    int         mismatches;
    int         requests_taken;
    int         writes_checked;

    function new();
      full_code = rgbseq_pkg::FULL_CODE_RESET;
      foreach (prev_level[c]) prev_level[c] = rgbseq_pkg::LEVEL_UNSEEN;
      prev_mask = rgbseq_pkg::MASK_UNSEEN;
      mismatches = 0;
      requests_taken = 0;
      writes_checked = 0;
    endfunction

    function logic [6:0] limit_level(logic [7:0] raw);
      return (raw > {1'b0, rgbseq_pkg::LEVEL_MAX}) ? rgbseq_pkg::LEVEL_MAX : raw[6:0];
    endfunction

    function void take_request(logic [7:0] red_raw, logic [7:0] green_raw,
                               logic [7:0] blue_raw);
      logic [6:0] level[3];
      logic [7:0] keep_bits[3];
      logic [7:0] on_bits[3];
      logic [1:0] reg_addr[3];
      logic [7:0] mask;
      reg_write_t burst[$];
      reg_write_t w;
      int         drive;
      level[RED]   = limit_level(red_raw);
      level[GREEN] = limit_level(green_raw);
      level[BLUE]  = limit_level(blue_raw);
      keep_bits = '{rgbseq_pkg::KEEP_RED, rgbseq_pkg::KEEP_GREEN, rgbseq_pkg::KEEP_BLUE};
      on_bits   = '{rgbseq_pkg::ON_RED, rgbseq_pkg::ON_GREEN, rgbseq_pkg::ON_BLUE};
      reg_addr  = '{rgbseq_pkg::ADDR_RED, rgbseq_pkg::ADDR_GREEN, rgbseq_pkg::ADDR_BLUE};
      mask = (prev_mask == rgbseq_pkg::MASK_UNSEEN) ? rgbseq_pkg::MASK_START : prev_mask;
      for (int c = RED; c <= BLUE; c++) begin
        if (level[c] != prev_level[c]) begin
          prev_level[c] = level[c];
          if (level[c] == 7'd0) begin
            mask = mask & keep_bits[c];
          end else begin
            mask = mask | on_bits[c];
            drive = ((int'(level[c]) - 1) * int'(full_code)) / SCALE_DIV;
            w.address = reg_addr[c];
            w.value = drive[7:0];
            w.last_write = 1'b0;
            burst.push_back(w);
          end
        end
      end
      if (mask != prev_mask) begin
        prev_mask = mask;
        w.address = rgbseq_pkg::ADDR_ENABLE;
        w.value = mask;
        w.last_write = 1'b0;
        burst.push_back(w);
      end
      foreach (burst[i]) begin
        w = burst[i];
        w.last_write = (i == burst.size() - 1);
        pending_writes.push_back(w);
      end
      requests_taken++;
    endfunction

    function void check_write(logic [1:0] address, logic [7:0] value, logic last_write);
      reg_write_t exp_w;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual address %0d value 0x%02h last %0b",
                 $time, address, value, last_write);
        mismatches++;
        return;
      end
      exp_w = pending_writes.pop_front();
      if (address !== exp_w.address) begin
        $display("%0t: address expected %0d actual %0d", $time, exp_w.address, address);
        mismatches++;
      end
      if (value !== exp_w.value) begin
        $display("%0t: value at address %0d expected 0x%02h actual 0x%02h",
                 $time, exp_w.address, exp_w.value, value);
        mismatches++;
      end
      if (last_write !== exp_w.last_write) begin
        $display("%0t: last flag at address %0d expected %0b actual %0b",
                 $time, exp_w.address, exp_w.last_write, last_write);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  bit         gaps_on;
  bit         stalls_on;
  int         quiet_cycles;
  logic [7:0] last_raw[3];
  logic [7:0] phase_codes[PHASE_COUNT];
  logic [23:0] directed_reqs[19];

  led_write_board board;

  rgbseq_in_if  in_ch ();
  rgbseq_out_if out_ch ();

  rgb_led_register_write_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_ch),
    .out_req     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_request(input logic [7:0] red_raw, input logic [7:0] green_raw,
                              input logic [7:0] blue_raw);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.red_level <= red_raw;
    in_ch.green_level <= green_raw;
    in_ch.blue_level <= blue_raw;
    do @(posedge clk); while (!in_ch.ready);
    board.take_request(red_raw, green_raw, blue_raw);
    last_raw[RED] = red_raw;
    last_raw[GREEN] = green_raw;
    last_raw[BLUE] = blue_raw;
  endtask

  // Mostly fresh levels in range, with repeats, zeros and clamped values mixed in.
  function automatic logic [7:0] pick_level(int c);
    case ($urandom_range(0, 9))
      0, 1: begin
        return last_raw[c];
      end
      2: begin
        return 8'd0;
      end
      3: begin
        return 8'($urandom_range(101, 255));
      end
      4: begin
        return 8'd100;
      end
      default: begin
        return 8'($urandom_range(1, 100));
      end
    endcase
  endfunction

  task automatic set_full_code(input logic [7:0] code);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.full_code = code;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_write(out_ch.reg_address, out_ch.reg_value, out_ch.last_write);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles, %0d writes still awaited",
               $time, QUIET_LIMIT, board.pending_writes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.red_level = 8'd0;
    in_ch.green_level = 8'd0;
    in_ch.blue_level = 8'd0;
    quiet_cycles = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    last_raw = '{8'd0, 8'd0, 8'd0};
    board = new();
    // The first request must end with an enable write even though every level goes to zero.
    directed_reqs = '{24'h000000, 24'h000000, 24'h646464, 24'hFFC865, 24'h010101,
                      24'h023263, 24'h003263, 24'h80807F, 24'h55AA33, 24'h640000,
                      24'h006400, 24'h000064, 24'h252525, 24'hFF0000, 24'h00FF00,
                      24'h0000FF, 24'hABCDEF, 24'h000000, 24'h646464};
    phase_codes = '{8'd0, 8'd255, 8'd1, 8'd99, 8'd100, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255))};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i][23:16], directed_reqs[i][15:8], directed_reqs[i][7:0]);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_full_code(phase_codes[p]);
      if (p == PHASE_COUNT - 1) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (PHASE_REQS) begin
        send_request(pick_level(RED), pick_level(GREEN), pick_level(BLUE));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d register writes over %0d full power settings,",
             board.requests_taken, board.writes_checked, PHASE_COUNT + 1);
    $display("with clamped, repeated and zero levels and random idling on both sides.");
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rgbseq_pkg.sv
rtl/rgbseq_if.sv
rtl/rgbseq_decide.sv
rtl/rgbseq_burst.sv
rtl/rgb_led_register_write_sequencer.sv
dv/tb.sv
